@@ sv/rrts_pkg.sv @@
package rrts_pkg;

    localparam int MAX_PROCS_DEF = 32;
    localparam int TIME_BITS_DEF = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM   = 2'd1;

    localparam logic [5:0] NUM_PROCS_RST = 6'd1;
    localparam logic [7:0] QUANTUM_RST   = 8'd4;

    localparam logic [1:0] PS_IDLE   = 2'd0;
    localparam logic [1:0] PS_QUEUED = 2'd1;
    localparam logic [1:0] PS_DONE   = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [4:0]  proc_index;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
    } sched_in_t;

    typedef struct packed {
        logic [4:0]  running_id;
        logic        running_valid;
        logic [31:0] total_wait;
        logic        all_done;
    } sched_out_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_RING_RD,
        S_BURST_RD,
        S_EXEC,
        S_RESULT
    } state_t;

endpackage

@@ sv/rrts_ring.sv @@
module rrts_ring #(
    parameter int MAX_PROCS = rrts_pkg::MAX_PROCS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rrts_pkg::ring_ctl_t                ctl,
    input  logic [$clog2(MAX_PROCS)-1:0]       push_id,
    output logic [$clog2(MAX_PROCS)-1:0]       head_id,
    output logic [$clog2(MAX_PROCS+1)-1:0]     count
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    logic [IDX_W-1:0] ring_mem [MAX_PROCS];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rd_data_reg;
    logic             push_ok;

    // A push into a full ring is dropped unless the head leaves in the same cycle.
    assign push_ok = ctl.push && ((int'(count_reg) < MAX_PROCS) || ctl.pop);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next = ((int'(head_reg) + 1) >= MAX_PROCS) ? '0 : head_reg + 1'b1;
        end
        if (push_ok)
        begin
            tail_next = ((int'(tail_reg) + 1) >= MAX_PROCS) ? '0 : tail_reg + 1'b1;
        end
        if (push_ok && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            ring_mem[tail_reg] <= push_id;
        end
        rd_data_reg <= ring_mem[head_reg];
    end

    assign head_id = rd_data_reg;
    assign count   = count_reg;

endmodule

@@ sv/round_robin_tick_scheduler.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    rrts_pkg::sched_in_t
// out      output     out_valid/out_stall  rrts_pkg::sched_out_t
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load and a tick each make one pipelined pass over the arrival and burst memories
// that visits one entry per cycle over the N table entries in use; a tick that finds
// the ring not empty then reads the ring head and its burst in turn.
// Reset clears the scheduler state at once; the table memories need no clearing.
// The result sits in an output register, so a new transaction is taken while it
// is stalled; a second result waits until the first one leaves.
module round_robin_tick_scheduler #(
    parameter int MAX_PROCS = rrts_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = rrts_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rrts_pkg::sched_in_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output rrts_pkg::sched_out_t                out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                          cfg_data
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int NW    = (CNT_W > 6) ? CNT_W : 6;

    rrts_pkg::state_t    state_reg, state_next;
    rrts_pkg::sched_in_t item_reg;
    rrts_pkg::sched_out_t out_reg;
    logic                out_valid_reg;

    logic [5:0]           num_procs_reg;
    logic [7:0]           quantum_reg;
    logic [NW-1:0]        scan_idx_reg, scan_idx_next;
    logic                 pipe_valid_reg, pipe_valid_next;
    logic [IDX_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic [CNT_W-1:0]     notdone_reg, notdone_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [7:0]           qleft_reg, qleft_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [31:0]          wait_reg, wait_next;
    logic [4:0]           res_id_reg, res_id_next;
    logic                 res_run_reg, res_run_next;
    logic                 res_done_reg, res_done_next;

    logic [1:0]           ps_reg [MAX_PROCS];
    logic                 ps_wr_en;
    logic [IDX_W-1:0]     ps_wr_addr;
    logic [1:0]           ps_wr_data;

    logic [TIME_BITS-1:0] arr_mem   [MAX_PROCS];
    logic [TIME_BITS-1:0] burst_mem [MAX_PROCS];
    logic [TIME_BITS-1:0] arr_q, burst_q;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic                 arr_wr_en;
    logic                 burst_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [TIME_BITS-1:0] burst_wr_data;

    rrts_pkg::ring_ctl_t  ring_ctl;
    logic [IDX_W-1:0]     ring_push_id;
    logic [IDX_W-1:0]     ring_head_id;
    logic [CNT_W-1:0]     ring_count;

    logic [NW-1:0]        n_eff;
    logic [IDX_W-1:0]     load_idx;
    logic                 load_ok;
    logic [TIME_BITS-1:0] load_burst;
    logic [7:0]           q_eff;
    logic [7:0]           q_cur;
    logic [7:0]           q_dec;
    logic [TIME_BITS-1:0] burst_dec;
    logic                 finished;
    logic [CNT_W-1:0]     waiting;
    logic [32:0]          wait_sum;
    logic [1:0]           pipe_st;

    rrts_ring #(
        .MAX_PROCS (MAX_PROCS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .push_id (ring_push_id),
        .head_id (ring_head_id),
        .count   (ring_count)
    );

    assign n_eff      = (int'(num_procs_reg) > MAX_PROCS) ? NW'(MAX_PROCS) : NW'(num_procs_reg);
    assign load_idx   = IDX_W'(item_reg.proc_index);
    assign load_ok    = int'(item_reg.proc_index) < MAX_PROCS;
    assign load_burst = TIME_BITS'(item_reg.burst_time);
    assign q_eff      = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
    assign q_cur      = (qleft_reg == 8'd0) ? q_eff : qleft_reg;
    assign q_dec      = q_cur - 8'd1;
    assign burst_dec  = (burst_q != '0) ? burst_q - 1'b1 : burst_q;
    assign finished   = (burst_dec == '0);
    assign waiting    = ring_count - 1'b1;
    assign wait_sum   = {1'b0, wait_reg} + 33'(waiting);
    assign pipe_st    = ps_reg[pipe_idx_reg];

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_idx_next   = pipe_idx_reg;
        notdone_next    = notdone_reg;
        head_next       = head_reg;
        qleft_next      = qleft_reg;
        tick_next       = tick_reg;
        wait_next       = wait_reg;
        res_id_next     = res_id_reg;
        res_run_next    = res_run_reg;
        res_done_next   = res_done_reg;
        ps_wr_en        = 1'b0;
        ps_wr_addr      = load_idx;
        ps_wr_data      = rrts_pkg::PS_IDLE;
        arr_wr_en       = 1'b0;
        burst_wr_en     = 1'b0;
        mem_wr_addr     = load_idx;
        burst_wr_data   = load_burst;
        mem_rd_addr     = scan_idx_reg[IDX_W-1:0];
        ring_ctl        = '0;
        ring_push_id    = pipe_idx_reg;

        case (state_reg)
            rrts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    scan_idx_next   = '0;
                    pipe_valid_next = 1'b0;
                    notdone_next    = '0;
                    state_next      = in_data.mode ? rrts_pkg::S_SCAN : rrts_pkg::S_LOAD;
                end
            end

            rrts_pkg::S_LOAD:
            begin
                if (load_ok)
                begin
                    arr_wr_en   = 1'b1;
                    burst_wr_en = 1'b1;
                    if (ps_reg[load_idx] != rrts_pkg::PS_QUEUED)
                    begin
                        ps_wr_en   = 1'b1;
                        ps_wr_data = (load_burst == '0) ? rrts_pkg::PS_DONE : rrts_pkg::PS_IDLE;
                    end
                end
                state_next = rrts_pkg::S_SCAN;
            end

            rrts_pkg::S_SCAN:
            begin
                if (scan_idx_reg < n_eff)
                begin
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next   = scan_idx_reg + 1'b1;
                end
                else
                begin
                    pipe_valid_next = 1'b0;
                end

                // Memory data for the entry issued last cycle is checked here.
                if (pipe_valid_reg)
                begin
                    if (item_reg.mode && pipe_st == rrts_pkg::PS_IDLE && arr_q == tick_reg &&
                        burst_q != '0)
                    begin
                        ps_wr_en      = 1'b1;
                        ps_wr_addr    = pipe_idx_reg;
                        ps_wr_data    = rrts_pkg::PS_QUEUED;
                        ring_ctl.push = 1'b1;
                    end
                    if (pipe_st != rrts_pkg::PS_DONE)
                    begin
                        notdone_next = notdone_reg + 1'b1;
                    end
                end

                if (scan_idx_reg >= n_eff && !pipe_valid_reg)
                begin
                    res_id_next   = '0;
                    res_run_next  = 1'b0;
                    res_done_next = (notdone_reg == '0);
                    if (item_reg.mode && ring_count != '0)
                    begin
                        state_next = rrts_pkg::S_RING_RD;
                    end
                    else
                    begin
                        if (item_reg.mode)
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                        state_next = rrts_pkg::S_RESULT;
                    end
                end
            end

            rrts_pkg::S_RING_RD:
            begin
                state_next = rrts_pkg::S_BURST_RD;
            end

            rrts_pkg::S_BURST_RD:
            begin
                head_next   = ring_head_id;
                mem_rd_addr = ring_head_id;
                state_next  = rrts_pkg::S_EXEC;
            end

            rrts_pkg::S_EXEC:
            begin
                burst_wr_en   = 1'b1;
                mem_wr_addr   = head_reg;
                burst_wr_data = burst_dec;
                ring_push_id  = head_reg;
                if (finished)
                begin
                    ring_ctl.pop = 1'b1;
                    ps_wr_en     = 1'b1;
                    ps_wr_addr   = head_reg;
                    ps_wr_data   = rrts_pkg::PS_DONE;
                    qleft_next   = 8'd0;
                end
                else if (q_dec == 8'd0)
                begin
                    ring_ctl.pop  = 1'b1;
                    ring_ctl.push = 1'b1;
                    qleft_next    = 8'd0;
                end
                else
                begin
                    qleft_next = q_dec;
                end
                wait_next    = wait_sum[32] ? 32'hFFFF_FFFF : wait_sum[31:0];
                tick_next    = tick_reg + 1'b1;
                res_id_next  = 5'(head_reg);
                res_run_next = 1'b1;
                // The head was counted as unfinished during the pass if it is in use.
                res_done_next = (notdone_reg ==
                    ((finished && (NW'(head_reg) < n_eff)) ? CNT_W'(1) : CNT_W'(0)));
                state_next = rrts_pkg::S_RESULT;
            end

            rrts_pkg::S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = rrts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrts_pkg::S_IDLE;
            num_procs_reg  <= rrts_pkg::NUM_PROCS_RST;
            quantum_reg    <= rrts_pkg::QUANTUM_RST;
            scan_idx_reg   <= '0;
            pipe_valid_reg <= 1'b0;
            notdone_reg    <= '0;
            qleft_reg      <= '0;
            tick_reg       <= '0;
            wait_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                ps_reg[i] <= rrts_pkg::PS_IDLE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            pipe_valid_reg <= pipe_valid_next;
            notdone_reg    <= notdone_next;
            qleft_reg      <= qleft_next;
            tick_reg       <= tick_next;
            wait_reg       <= wait_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rrts_pkg::CFG_NUM_PROCS: num_procs_reg <= cfg_data[5:0];
                    rrts_pkg::CFG_QUANTUM:   quantum_reg   <= cfg_data;
                    default:                 ;
                endcase
            end
            if (ps_wr_en)
            begin
                ps_reg[ps_wr_addr] <= ps_wr_data;
            end
            if (state_reg == rrts_pkg::S_RESULT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= pipe_idx_next;
        head_reg     <= head_next;
        res_id_reg   <= res_id_next;
        res_run_reg  <= res_run_next;
        res_done_reg <= res_done_next;
        if (state_reg == rrts_pkg::S_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == rrts_pkg::S_RESULT && (!out_valid_reg || !out_stall))
        begin
            out_reg.running_id    <= res_id_reg;
            out_reg.running_valid <= res_run_reg;
            out_reg.total_wait    <= wait_reg;
            out_reg.all_done      <= res_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (arr_wr_en)
        begin
            arr_mem[mem_wr_addr] <= TIME_BITS'(item_reg.arrival_time);
        end
        if (burst_wr_en)
        begin
            burst_mem[mem_wr_addr] <= burst_wr_data;
        end
        arr_q   <= arr_mem[mem_rd_addr];
        burst_q <= burst_mem[mem_rd_addr];
    end

    assign in_stall  = (state_reg != rrts_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule
